>>> src/llr_boxplus_piecewise_tanh_core_assert.svh
// Assertion macros used by the box-plus core checker.
`ifndef LLR_BOXPLUS_PIECEWISE_TANH_CORE_ASSERT_SVH
`define LLR_BOXPLUS_PIECEWISE_TANH_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LBPT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box-plus core implication check failed");

// Condition that must never be seen outside reset.
`define LBPT_ASSERT_NEVER(name, bad) \
  name: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error("box-plus core forbidden condition seen");

`endif

>>> src/lbpt_pkg.sv
// Package with the piecewise-linear tanh/atanh segment tables and helpers.
package lbpt_pkg;

  localparam int TQ     = 22;  // fraction bits of tanh values
  localparam int SQ     = 30;  // fraction bits of line slopes
  localparam int RQ     = 16;  // fraction bits of reciprocal slopes
  localparam int NSEG   = 26;
  localparam int SEG_W  = 5;
  localparam int SLOPE_W = 30;
  localparam int ICPT_W  = 22;
  localparam int RECIP_W = 34;
  localparam int TV_W    = 23;  // tanh value with one guard bit

  localparam longint unsigned MICRO    = 64'd1000000;
  localparam longint unsigned MicroQ16 = MICRO << RQ;

  typedef logic [SEG_W-1:0] seg_idx_t;

  localparam seg_idx_t SEG_SAT = SEG_W'(NSEG);

  localparam logic [ICPT_W-1:0] TANH_SAT =
    ICPT_W'((((64'd999998) << TQ) + MICRO / 2) / MICRO);

  // Upper breakpoints and line coefficients, in units of 1e-6.
  localparam longint unsigned TB_MICRO [NSEG] = '{
    200055, 407874, 630421, 871825, 1130889, 1401921, 1679040, 1958686,
    2239267, 2520170, 2801185, 3082237, 3363301, 3644369, 3925440, 4206509,
    4487578, 4768647, 5049716, 5330785, 5611854, 5892923, 6173992, 6455061,
    6736130, 7017199};
  localparam longint unsigned AB_MICRO [NSEG] = '{
    197428, 386666, 558342, 702300, 811323, 885766, 932737, 960989,
    977555, 987140, 992649, 995803, 997606, 998635, 999221, 999556,
    999747, 999856, 999918, 999953, 999973, 999985, 999991, 999995,
    999997, 999998};
  localparam longint unsigned S_MICRO [NSEG] = '{
    986900, 910600, 771400, 596300, 420800, 274700, 169500, 101000,
    59000, 34100, 19600, 11200, 6400, 3700, 2100, 1200,
    700, 400, 200, 120, 70, 43, 21, 14, 7, 4};
  localparam longint unsigned C_MICRO [NSEG] = '{
    0, 15300, 72000, 182400, 335400, 500700, 648100, 763200,
    845400, 901200, 937700, 961300, 976100, 985200, 991000, 994500,
    996600, 997950, 998900, 999300, 999580, 999730, 999860, 999900,
    999950, 999970};

  // Reciprocal slopes in Q16, rounded to nearest.
  localparam longint unsigned RECIP_Q16 [NSEG] = '{
    (MicroQ16 + S_MICRO[0] / 2) / S_MICRO[0],
    (MicroQ16 + S_MICRO[1] / 2) / S_MICRO[1],
    (MicroQ16 + S_MICRO[2] / 2) / S_MICRO[2],
    (MicroQ16 + S_MICRO[3] / 2) / S_MICRO[3],
    (MicroQ16 + S_MICRO[4] / 2) / S_MICRO[4],
    (MicroQ16 + S_MICRO[5] / 2) / S_MICRO[5],
    (MicroQ16 + S_MICRO[6] / 2) / S_MICRO[6],
    (MicroQ16 + S_MICRO[7] / 2) / S_MICRO[7],
    (MicroQ16 + S_MICRO[8] / 2) / S_MICRO[8],
    (MicroQ16 + S_MICRO[9] / 2) / S_MICRO[9],
    (MicroQ16 + S_MICRO[10] / 2) / S_MICRO[10],
    (MicroQ16 + S_MICRO[11] / 2) / S_MICRO[11],
    (MicroQ16 + S_MICRO[12] / 2) / S_MICRO[12],
    (MicroQ16 + S_MICRO[13] / 2) / S_MICRO[13],
    (MicroQ16 + S_MICRO[14] / 2) / S_MICRO[14],
    (MicroQ16 + S_MICRO[15] / 2) / S_MICRO[15],
    (MicroQ16 + S_MICRO[16] / 2) / S_MICRO[16],
    (MicroQ16 + S_MICRO[17] / 2) / S_MICRO[17],
    (MicroQ16 + S_MICRO[18] / 2) / S_MICRO[18],
    (MicroQ16 + S_MICRO[19] / 2) / S_MICRO[19],
    (MicroQ16 + S_MICRO[20] / 2) / S_MICRO[20],
    (MicroQ16 + S_MICRO[21] / 2) / S_MICRO[21],
    (MicroQ16 + S_MICRO[22] / 2) / S_MICRO[22],
    (MicroQ16 + S_MICRO[23] / 2) / S_MICRO[23],
    (MicroQ16 + S_MICRO[24] / 2) / S_MICRO[24],
    (MicroQ16 + S_MICRO[25] / 2) / S_MICRO[25]};

  function automatic logic [SLOPE_W-1:0] slope_q30(input int k);
    return SLOPE_W'(((S_MICRO[k] << SQ) + MICRO / 2) / MICRO);
  endfunction

  function automatic logic [ICPT_W-1:0] icpt_q22(input int k);
    return ICPT_W'(((C_MICRO[k] << TQ) + MICRO / 2) / MICRO);
  endfunction

  function automatic logic [RECIP_W-1:0] recip_q16(input int k);
    return RECIP_W'(RECIP_Q16[k]);
  endfunction

  // Largest LLR magnitude that still falls in tanh segment k.
  function automatic logic [31:0] tanh_bp(input int k, input int fb);
    return 32'((TB_MICRO[k] << (fb + 1)) / MICRO);
  endfunction

  // Largest Q22 value that still falls in atanh segment k.
  function automatic logic [31:0] atanh_bp(input int k);
    return 32'((AB_MICRO[k] << TQ) / MICRO);
  endfunction

  function automatic logic [31:0] atanh2_sat(input int fb);
    return 32'(((64'd14034398 << fb) + MICRO / 2) / MICRO);
  endfunction

endpackage

>>> src/llr_boxplus_piecewise_tanh_core.sv
// Box-plus LLR combiner built from piecewise-linear tanh and atanh pipelines.
// A result appears with done once the item has passed all eight register stages.
// Throughput: one item per cycle; busy is low whenever reset is low.
// The eight register stages hold compare banks, multipliers and adds.
// Reset (rst, synchronous) clears the valid bits of every stage; busy is high during reset.
// The receiver cannot stall, so results leave on done without any backpressure.
module llr_boxplus_piecewise_tanh_core #(
  parameter int LLR_WIDTH = 16,
  parameter int FRAC_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [LLR_WIDTH-1:0] llr_a,
  input  logic signed [LLR_WIDTH-1:0] llr_b,
  output logic                        done,
  output logic signed [LLR_WIDTH-1:0] llr_out
);
  import lbpt_pkg::*;

  // Tanh product width, rounding shifts and the widths that follow from them.
  localparam int PW   = SLOPE_W + LLR_WIDTH;      // slope times magnitude
  localparam int TSH  = SQ + FRAC_BITS + 1 - TQ;  // Q30*Q(F+1) down to Q22
  localparam int PPW  = 2 * TV_W;                 // tanh product
  localparam int PRW  = PPW + 1 - TQ;             // rounded product, Q22
  localparam int DW   = ICPT_W;                   // distance above intercept
  localparam int QW   = DW + RECIP_W;             // distance times reciprocal
  localparam int ASH  = TQ + RQ - FRAC_BITS - 1;  // Q38 down to Q(F+1)
  localparam int MW   = QW + 1;

  localparam logic [MW-1:0] ATANH_SAT_M = MW'(atanh2_sat(FRAC_BITS));
  localparam logic [MW-1:0] LLR_MAXMAG  = MW'((64'd1 << (LLR_WIDTH - 1)) - 64'd1);

  // Two's-complement magnitude; the most negative code maps to 2^(LLR_WIDTH-1).
  function automatic logic [LLR_WIDTH-1:0] llr_mag(input logic [LLR_WIDTH-1:0] raw);
    return raw[LLR_WIDTH-1] ? (~raw + LLR_WIDTH'(1)) : raw;
  endfunction

  // Lowest tanh segment whose upper breakpoint is not below the magnitude.
  function automatic seg_idx_t tanh_seg(input logic [LLR_WIDTH-1:0] mag);
    seg_idx_t seg;
    seg = SEG_SAT;
    for (int k = NSEG - 1; k >= 0; k--) begin
      if (32'(mag) <= tanh_bp(k, FRAC_BITS)) begin
        seg = SEG_W'(k);
      end
    end
    return seg;
  endfunction

  // The block never holds off an item outside reset.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: magnitudes, joint sign and tanh segment lookup.
  logic                 v1;
  logic [LLR_WIDTH-1:0] am1, bm1;
  logic                 neg1;
  seg_idx_t             sa1, sb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    am1  <= llr_mag(llr_a);
    bm1  <= llr_mag(llr_b);
    neg1 <= llr_a[LLR_WIDTH-1] ^ llr_b[LLR_WIDTH-1];
    sa1  <= tanh_seg(llr_mag(llr_a));
    sb1  <= tanh_seg(llr_mag(llr_b));
  end

  // Stage 2: slope multiply for both operands; the intercept rides along.
  logic [SLOPE_W-1:0] slope_a, slope_b;
  logic [ICPT_W-1:0]  icpt_a, icpt_b;

  always_comb begin
    slope_a = '0;
    slope_b = '0;
    icpt_a  = '0;
    icpt_b  = '0;
    for (int k = 0; k < NSEG; k++) begin
      if (sa1 == SEG_W'(k)) begin
        slope_a = slope_q30(k);
        icpt_a  = icpt_q22(k);
      end
      if (sb1 == SEG_W'(k)) begin
        slope_b = slope_q30(k);
        icpt_b  = icpt_q22(k);
      end
    end
  end

  logic              v2;
  logic [PW-1:0]     prod_a2, prod_b2;
  logic [ICPT_W-1:0] icpt_a2, icpt_b2;
  logic              sat_a2, sat_b2;
  logic              neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    prod_a2 <= PW'(slope_a) * PW'(am1);
    prod_b2 <= PW'(slope_b) * PW'(bm1);
    icpt_a2 <= icpt_a;
    icpt_b2 <= icpt_b;
    sat_a2  <= (sa1 == SEG_SAT);
    sat_b2  <= (sb1 == SEG_SAT);
    neg2    <= neg1;
  end

  // Stage 3: round the slope product to Q22 and add the intercept.
  logic [PW:0]     rnd_a, rnd_b;
  logic [TV_W-1:0] ta_next, tb_next;

  always_comb begin
    rnd_a   = {1'b0, prod_a2} + ((PW + 1)'(1) << (TSH - 1));
    rnd_b   = {1'b0, prod_b2} + ((PW + 1)'(1) << (TSH - 1));
    ta_next = sat_a2 ? TV_W'(TANH_SAT) : (TV_W'(rnd_a >> TSH) + TV_W'(icpt_a2));
    tb_next = sat_b2 ? TV_W'(TANH_SAT) : (TV_W'(rnd_b >> TSH) + TV_W'(icpt_b2));
  end

  logic            v3;
  logic [TV_W-1:0] ta3, tb3;
  logic            neg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    ta3  <= ta_next;
    tb3  <= tb_next;
    neg3 <= neg2;
  end

  // Stage 4: product of the two tanh values.
  logic           v4;
  logic [PPW-1:0] pp4;
  logic           neg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    pp4  <= PPW'(ta3) * PPW'(tb3);
    neg4 <= neg3;
  end

  // Stage 5: round the product back to Q22.
  logic [PPW:0] pp_rnd;
  assign pp_rnd = {1'b0, pp4} + ((PPW + 1)'(1) << (TQ - 1));

  logic           v5;
  logic [PRW-1:0] p5;
  logic           neg5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    p5   <= PRW'(pp_rnd >> TQ);
    neg5 <= neg4;
  end

  // Stage 6: atanh segment lookup, then distance of the product above the
  // segment's intercept. In the saturated case the distance is unused.
  seg_idx_t           aseg;
  logic [ICPT_W-1:0]  aicpt;
  logic [RECIP_W-1:0] arecip;
  logic [DW-1:0]      d_next;

  always_comb begin
    aseg = SEG_SAT;
    for (int k = NSEG - 1; k >= 0; k--) begin
      if (32'(p5) <= atanh_bp(k)) begin
        aseg = SEG_W'(k);
      end
    end
    aicpt  = '0;
    arecip = '0;
    for (int k = 0; k < NSEG; k++) begin
      if (aseg == SEG_W'(k)) begin
        aicpt  = icpt_q22(k);
        arecip = recip_q16(k);
      end
    end
    d_next = (p5 > PRW'(aicpt)) ? DW'(p5 - PRW'(aicpt)) : '0;
  end

  logic               v6;
  logic [DW-1:0]      d6;
  logic [RECIP_W-1:0] recip6;
  logic               asat6;
  logic               neg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    d6     <= d_next;
    recip6 <= arecip;
    asat6  <= (aseg == SEG_SAT);
    neg6   <= neg5;
  end

  // Stage 7: divide by the slope as a multiply by its reciprocal.
  logic          v7;
  logic [QW-1:0] q7;
  logic          asat7;
  logic          neg7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    q7    <= QW'(d6) * QW'(recip6);
    asat7 <= asat6;
    neg7  <= neg6;
  end

  // Stage 8: round to the LLR grid, clamp symmetrically and apply the sign.
  logic [MW-1:0]          m_rnd, m_mag;
  logic [LLR_WIDTH-2:0]   m_clip;
  logic [LLR_WIDTH-1:0]   out_next;

  always_comb begin
    m_rnd    = {1'b0, q7} + (MW'(1) << (ASH - 1));
    m_mag    = asat7 ? ATANH_SAT_M : (m_rnd >> ASH);
    m_clip   = (m_mag > LLR_MAXMAG) ? (LLR_WIDTH - 1)'(LLR_MAXMAG)
                                    : (LLR_WIDTH - 1)'(m_mag);
    out_next = neg7 ? (~{1'b0, m_clip} + LLR_WIDTH'(1)) : {1'b0, m_clip};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
    llr_out <= out_next;
  end

endmodule

>>> src/lbpt_chk.sv
// Port-level checker for the box-plus core and its bind to the top level.
`include "llr_boxplus_piecewise_tanh_core_assert.svh"

module lbpt_chk #(
  parameter int LLR_WIDTH = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic signed [LLR_WIDTH-1:0] llr_a,
  input logic signed [LLR_WIDTH-1:0] llr_b,
  input logic                        done,
  input logic signed [LLR_WIDTH-1:0] llr_out
);
  localparam logic [LLR_WIDTH-1:0] LLR_MIN = {1'b1, {(LLR_WIDTH - 1){1'b0}}};

  // Every accepted item yields its result on done.
  `LBPT_ASSERT_IMPL(a_item_to_done, start && !busy, ##8 done)

  // No result appears on done without a matching accepted item.
  `LBPT_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy, 8))

  // A zero LLR on either side makes the combination zero.
  `LBPT_ASSERT_IMPL(a_zero_in_zero_out,
    done && ($past(llr_a, 8) == 0 || $past(llr_b, 8) == 0), llr_out == 0)

  // The output clamp is symmetric, so the most negative code never shows up.
  `LBPT_ASSERT_NEVER(a_no_min_code, done && llr_out == LLR_MIN)

endmodule

bind llr_boxplus_piecewise_tanh_core lbpt_chk #(
  .LLR_WIDTH(LLR_WIDTH)
) u_lbpt_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .llr_a   (llr_a),
  .llr_b   (llr_b),
  .done    (done),
  .llr_out (llr_out)
);

>>> verif/llr_boxplus_piecewise_tanh_core_test.sv
// Self-checking testbench for the piecewise-linear box-plus LLR core.
module llr_boxplus_piecewise_tanh_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LLR_W = 16;
  localparam int FB    = 10;
  localparam int NKNEE = 26;

  // Rounding shifts of the two line evaluations.
  localparam int TANH_SH  = 30 + FB + 1 - 22;
  localparam int ATANH_SH = 22 + 16 - FB - 1;

  localparam longint unsigned PPM = 64'd1000000;

  // Run length and watchdog.  The slowest correct run has every item
  // preceded by the longest pause plus the pipeline, still well under
  // CYCLE_LIMIT for this item count.
  localparam int N_RANDOM    = 1600;
  localparam int CALM_TAIL   = 300;
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 200000;

  // Line table in units of 1e-6: the upper knee on the tanh side (in
  // units of x, where the core evaluates tanh(|llr|/2)), the upper knee on
  // the atanh side, then slope and offset of each line.
  localparam longint unsigned TANH_KNEE [NKNEE] = '{
    200055, 407874, 630421, 871825, 1130889, 1401921, 1679040, 1958686,
    2239267, 2520170, 2801185, 3082237, 3363301, 3644369, 3925440, 4206509,
    4487578, 4768647, 5049716, 5330785, 5611854, 5892923, 6173992, 6455061,
    6736130, 7017199};
  localparam longint unsigned ATANH_KNEE [NKNEE] = '{
    197428, 386666, 558342, 702300, 811323, 885766, 932737, 960989,
    977555, 987140, 992649, 995803, 997606, 998635, 999221, 999556,
    999747, 999856, 999918, 999953, 999973, 999985, 999991, 999995,
    999997, 999998};
  localparam longint unsigned LINE_SLOPE [NKNEE] = '{
    986900, 910600, 771400, 596300, 420800, 274700, 169500, 101000,
    59000, 34100, 19600, 11200, 6400, 3700, 2100, 1200,
    700, 400, 200, 120, 70, 43, 21, 14, 7, 4};
  localparam longint unsigned LINE_OFFSET [NKNEE] = '{
    0, 15300, 72000, 182400, 335400, 500700, 648100, 763200,
    845400, 901200, 937700, 961300, 976100, 985200, 991000, 994500,
    996600, 997950, 998900, 999300, 999580, 999730, 999860, 999900,
    999950, 999970};

  typedef logic signed [LLR_W-1:0] llr_t;

  typedef struct {
    llr_t a;
    llr_t b;
  } llr_pair_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  llr_t llr_a = '0;
  llr_t llr_b = '0;
  logic busy;
  logic done;
  llr_t llr_out;

  llr_pair_t pending_pairs[$];   // items still to be offered to the core
  llr_t      expected_llrs[$];   // box-plus results not yet seen on done

  int n_total    = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int cycles     = 0;
  int idle_left  = 0;

  llr_boxplus_piecewise_tanh_core #(
    .LLR_WIDTH(LLR_W),
    .FRAC_BITS(FB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .llr_a(llr_a),
    .llr_b(llr_b),
    .done(done),
    .llr_out(llr_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Box-plus predictor, exact integer arithmetic.
  // ---------------------------------------------------------------------

  // Decimal constant in millionths to Q(q), rounded to nearest.
  function automatic longint unsigned ppm_to_q(longint unsigned v, int q);
    return ((v << q) + PPM / 2) / PPM;
  endfunction

  // tanh(|llr|/2) in Q22.  The magnitude carries FB fraction bits, so read
  // with one more fraction bit it is already halved.  A magnitude exactly
  // on a knee stays on the lower line.
  function automatic longint unsigned half_tanh_q22(longint unsigned mag);
    longint unsigned prod;
    for (int k = 0; k < NKNEE; k++) begin
      if (mag * PPM <= (TANH_KNEE[k] << (FB + 1))) begin
        prod = ppm_to_q(LINE_SLOPE[k], 30) * mag;
        return ((prod + (64'd1 << (TANH_SH - 1))) >> TANH_SH) +
               ppm_to_q(LINE_OFFSET[k], 22);
      end
    end
    return ppm_to_q(64'd999998, 22);
  endfunction

  // 2*atanh(y) for y in Q22, as an LLR magnitude.  The division by the
  // slope is a multiplication by its Q16 reciprocal; values under the
  // offset of their line give zero.
  function automatic longint unsigned twice_atanh_llr(longint unsigned y);
    longint unsigned offs;
    longint unsigned recip;
    longint unsigned diff;
    for (int k = 0; k < NKNEE; k++) begin
      if (y * PPM <= (ATANH_KNEE[k] << 22)) begin
        offs  = ppm_to_q(LINE_OFFSET[k], 22);
        recip = ((PPM << 16) + LINE_SLOPE[k] / 2) / LINE_SLOPE[k];
        diff  = (y > offs) ? y - offs : 64'd0;
        return (diff * recip + (64'd1 << (ATANH_SH - 1))) >> ATANH_SH;
      end
    end
    return ppm_to_q(64'd14034398, FB);
  endfunction

  function automatic llr_t boxplus_llr(llr_t a, llr_t b);
    longint unsigned mag_a;
    longint unsigned mag_b;
    longint unsigned prod;
    longint unsigned mag;
    // The most negative input keeps its full magnitude of 2^(LLR_W-1).
    mag_a = a[LLR_W-1] ? (64'd1 << LLR_W) - longint'($unsigned(a)) : longint'(a);
    mag_b = b[LLR_W-1] ? (64'd1 << LLR_W) - longint'($unsigned(b)) : longint'(b);
    prod  = (half_tanh_q22(mag_a) * half_tanh_q22(mag_b) + (64'd1 << 21)) >> 22;
    mag   = twice_atanh_llr(prod);
    if (mag > (64'd1 << (LLR_W - 1)) - 1) mag = (64'd1 << (LLR_W - 1)) - 1;
    // Sign of the product: negative when exactly one input is negative.
    return (a[LLR_W-1] != b[LLR_W-1]) ? llr_t'(-mag) : llr_t'(mag);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus shaping.
  // ---------------------------------------------------------------------

  // LLR magnitude sitting right on a tanh knee, one below or one above.
  function automatic int knee_mag(int k, int offs);
    return int'((TANH_KNEE[k] << (FB + 1)) / PPM) + offs;
  endfunction

  // Most draws stay in the unsaturated range where the lines matter; some
  // land on tanh knees, some are tiny, and a quarter use all 16 bits so
  // that saturation, frozen-bit sized values and every bit are exercised.
  function automatic llr_t random_llr();
    int mode;
    int mag;
    mode = $urandom_range(0, 99);
    if (mode < 25) return llr_t'($urandom);
    if (mode < 65) mag = $urandom_range(0, 14500);
    else if (mode < 85) mag = knee_mag($urandom_range(0, NKNEE - 1), $urandom_range(0, 2) - 1);
    else mag = $urandom_range(0, 600);
    return $urandom_range(0, 1) ? llr_t'(-mag) : llr_t'(mag);
  endfunction

  function automatic void queue_pair(int a, int b);
    llr_pair_t p;
    p.a = llr_t'(a);
    p.b = llr_t'(b);
    pending_pairs.push_back(p);
    n_total++;
  endfunction

  // ---------------------------------------------------------------------
  // Driver.  An item is taken at an edge where start is high and busy is
  // low.  Between items the sender sometimes pauses; how often depends on
  // the stretch of the run, with calm stretches and no pauses at all near
  // the end.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    logic      offer;
    int        pause_pct;
    llr_pair_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      offer = start;
      if (start && !busy) begin
        expected_llrs.push_back(boxplus_llr(llr_a, llr_b));
        n_accepted++;
        offer = 1'b0;
      end
      case ((n_accepted / 128) % 4)
        0: pause_pct = 0;
        1: pause_pct = 30;
        2: pause_pct = 60;
        default: pause_pct = 15;
      endcase
      if (n_accepted >= n_total - CALM_TAIL) pause_pct = 0;
      if (!offer) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_pairs.size() > 0) begin
          if ($urandom_range(0, 99) < pause_pct) begin
            // This cycle is the first of the burst.
            idle_left = $urandom_range(0, 3);
          end else begin
            nxt = pending_pairs.pop_front();
            llr_a <= nxt.a;
            llr_b <= nxt.b;
            offer = 1'b1;
          end
        end
      end
      start <= offer;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor.  Every done cycle carries one result, checked against the
  // oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    llr_t want;
    if (!rst && done) begin
      if (expected_llrs.size() == 0) begin
        $error("llr_out: no result expected, got %0d", llr_out);
        n_errors++;
      end else begin
        want = expected_llrs.pop_front();
        if (llr_out !== want) begin
          $error("llr_out: expected %0d, got %0d", want, llr_out);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // Directed items: zeros, full-scale values of both signs including the
    // most negative code, mixed signs, and magnitudes right on and just past
    // the first, middle and last tanh knees.
    queue_pair(0, 0);
    queue_pair(0, 1000);
    queue_pair(-1000, 0);
    queue_pair(32767, 32767);
    queue_pair(-32768, -32768);
    queue_pair(-32768, 32767);
    queue_pair(32767, -32768);
    queue_pair(1, 1);
    queue_pair(-1, 1);
    queue_pair(knee_mag(0, 0), knee_mag(0, 0));
    queue_pair(knee_mag(0, 1), -knee_mag(0, 1));
    queue_pair(-knee_mag(12, 0), knee_mag(12, 0));
    queue_pair(knee_mag(12, 1), knee_mag(12, 1));
    queue_pair(knee_mag(25, 0), knee_mag(25, 0));
    queue_pair(knee_mag(25, 1), -knee_mag(25, 1));
    queue_pair(knee_mag(25, 0), 2048);
    queue_pair(-3000, 5000);
    queue_pair(1024, 1024);
    queue_pair(32767, 2048);
    queue_pair(-32768, 512);
    queue_pair(5, 32767);
    for (int i = 0; i < N_RANDOM; i++) queue_pair(random_llr(), random_llr());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_total);
    wait (expected_llrs.size() == 0);
    // The pipeline is eight deep; any stray done would show within this.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Combined %0d LLR pairs (directed edges, knees, saturation, random mix);",
             n_accepted);
    $display("checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
